@@ hw/rtl/nte_pkg.sv @@
// Package for the neighbor table: codes, state encoding and default sizes.
package nte_pkg;

    // Default table size and time width
    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned TIME_BITS_DEF   = 32;

    // Input transaction kinds
    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_TXERR  = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    // Result transaction kinds
    typedef enum logic [1:0] {
        RPT_FAILURE = 2'd0,
        RPT_ANSWER  = 2'd1,
        RPT_DONE    = 2'd2
    } rpt_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_PURGE_RD,
        ST_PURGE_EV,
        ST_FINAL
    } state_t;

endpackage

@@ hw/rtl/neighbor_table_with_expiry_unit.sv @@
// Neighbor table with expiry: entry memory, scan sequencer and result register.
//
// The table holds up to TABLE_DEPTH neighbor addresses, each with an absolute
// expiry time and a close mark, in a single-port-write, registered-read memory
// that starts empty (a fill count marks the live entries, no clearing pass).
// One transaction is processed at a time; s_ready is high only while the
// sequencer is idle, and a finished result may still wait in the output
// register while the next transaction is taken. Every entry visit is a memory
// read, then a compare and write back through one shared compare and subtract
// path. Query, transmit error and tick run one purge pass. Update first runs
// a search pass; a hit at entry k ends there, and a miss appends and purges
// (the insert is dropped when the table is full). Each reported removal and
// the final result wait while m_ready is held low. Each transaction yields
// zero or more link failure reports (when report_failures is set) followed by
// one final result with m_last set.
module neighbor_table_with_expiry_unit #(
    parameter int unsigned TABLE_DEPTH = nte_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned TIME_BITS   = nte_pkg::TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic [15:0]          s_addr,
    input  logic [TIME_BITS-1:0] s_lifetime,
    input  logic [TIME_BITS-1:0] s_now,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_report_kind,
    output logic [15:0]          m_link_addr,
    output logic                 m_found,
    output logic [TIME_BITS-1:0] m_remaining,
    output logic                 m_table_full,
    output logic                 m_last
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Entry memory
    logic [15:0]          mem_addr   [TABLE_DEPTH];
    logic [TIME_BITS-1:0] mem_exp    [TABLE_DEPTH];
    logic                 mem_closed [TABLE_DEPTH];

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [15:0]          mem_wd_addr;
    logic [TIME_BITS-1:0] mem_wd_exp;
    logic                 mem_wd_closed;
    logic [15:0]          rd_addr_reg;
    logic [TIME_BITS-1:0] rd_exp_reg;
    logic                 rd_closed_reg;

    // Control and transaction registers
    nte_pkg::state_t      state_reg, state_next;
    nte_pkg::kind_t       kind_reg, kind_next;
    logic [15:0]          addr_reg, addr_next;
    logic [TIME_BITS-1:0] life_reg, life_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 full_reg, full_next;
    logic                 found_reg, found_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic                 report_failures_reg;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    nte_pkg::rpt_kind_t   o_kind_reg, o_kind_next;
    logic [15:0]          o_addr_reg, o_addr_next;
    logic                 o_found_reg, o_found_next;
    logic [TIME_BITS-1:0] o_rem_reg, o_rem_next;
    logic                 o_full_reg, o_full_next;
    logic                 o_last_reg, o_last_next;

    // Shared arithmetic
    logic [TIME_BITS:0]   sum_wide;
    logic [TIME_BITS-1:0] exp_sat;
    logic                 addr_hit;
    logic                 expired;
    logic                 kill;
    logic                 out_free;
    logic                 scan_end;

    assign sum_wide = {1'b0, life_reg} + {1'b0, now_reg};
    assign exp_sat  = sum_wide[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_wide[TIME_BITS-1:0];
    assign addr_hit = (rd_addr_reg == addr_reg);
    assign expired  = (rd_exp_reg < now_reg);
    assign kill     = expired || rd_closed_reg ||
                      ((kind_reg == nte_pkg::KIND_TXERR) && addr_hit);
    assign out_free = !m_valid_reg || m_ready;
    assign scan_end = (idx_reg >= count_reg);

    // Write and read the entry memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_addr[mem_wa]   <= mem_wd_addr;
            mem_exp[mem_wa]    <= mem_wd_exp;
            mem_closed[mem_wa] <= mem_wd_closed;
        end
        rd_addr_reg   <= mem_addr[idx_reg[IDX_W-1:0]];
        rd_exp_reg    <= mem_exp[idx_reg[IDX_W-1:0]];
        rd_closed_reg <= mem_closed[idx_reg[IDX_W-1:0]];
    end

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_failures_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            report_failures_reg <= cfg_wr_data;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nte_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        life_reg    <= life_next;
        now_reg     <= now_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        full_reg    <= full_next;
        found_reg   <= found_next;
        rem_reg     <= rem_next;
        o_kind_reg  <= o_kind_next;
        o_addr_reg  <= o_addr_next;
        o_found_reg <= o_found_next;
        o_rem_reg   <= o_rem_next;
        o_full_reg  <= o_full_next;
        o_last_reg  <= o_last_next;
    end

    // Sequencer: next state, memory writes and result loads
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        life_next     = life_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        count_next    = count_reg;
        full_next     = full_reg;
        found_next    = found_reg;
        rem_next      = rem_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_kind_next   = o_kind_reg;
        o_addr_next   = o_addr_reg;
        o_found_next  = o_found_reg;
        o_rem_next    = o_rem_reg;
        o_full_next   = o_full_reg;
        o_last_next   = o_last_reg;
        mem_we        = 1'b0;
        mem_wa        = idx_reg[IDX_W-1:0];
        mem_wd_addr   = rd_addr_reg;
        mem_wd_exp    = rd_exp_reg;
        mem_wd_closed = rd_closed_reg;
        s_ready       = 1'b0;

        case (state_reg)
            nte_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = nte_pkg::kind_t'(s_kind);
                    addr_next  = s_addr;
                    life_next  = s_lifetime;
                    now_next   = s_now;
                    idx_next   = '0;
                    wr_next    = '0;
                    full_next  = 1'b0;
                    found_next = 1'b0;
                    rem_next   = '0;
                    if (nte_pkg::kind_t'(s_kind) == nte_pkg::KIND_UPDATE) begin
                        state_next = nte_pkg::ST_SRCH_RD;
                    end else begin
                        state_next = nte_pkg::ST_PURGE_RD;
                    end
                end
            end

            // Look up the address before inserting
            nte_pkg::ST_SRCH_RD: begin
                if (scan_end) begin
                    if (count_reg < DEPTH_CNT) begin
                        mem_we        = 1'b1;
                        mem_wa        = count_reg[IDX_W-1:0];
                        mem_wd_addr   = addr_reg;
                        mem_wd_exp    = exp_sat;
                        mem_wd_closed = 1'b0;
                        count_next    = count_reg + 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end
                    idx_next   = '0;
                    wr_next    = '0;
                    state_next = nte_pkg::ST_PURGE_RD;
                end else begin
                    state_next = nte_pkg::ST_SRCH_EV;
                end
            end

            nte_pkg::ST_SRCH_EV: begin
                if (addr_hit) begin
                    // Extend the expiry of a present entry, no purge
                    if (exp_sat > rd_exp_reg) begin
                        mem_we     = 1'b1;
                        mem_wd_exp = exp_sat;
                    end
                    state_next = nte_pkg::ST_FINAL;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = nte_pkg::ST_SRCH_RD;
                end
            end

            // Compact the table, dropping expired and closed entries and, on a transmit error, matching ones
            nte_pkg::ST_PURGE_RD: begin
                if (scan_end) begin
                    count_next = wr_reg;
                    state_next = nte_pkg::ST_FINAL;
                end else begin
                    state_next = nte_pkg::ST_PURGE_EV;
                end
            end

            nte_pkg::ST_PURGE_EV: begin
                if (kill) begin
                    if (!report_failures_reg) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = nte_pkg::ST_PURGE_RD;
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        o_kind_next  = nte_pkg::RPT_FAILURE;
                        o_addr_next  = rd_addr_reg;
                        o_found_next = 1'b0;
                        o_rem_next   = '0;
                        o_full_next  = 1'b0;
                        o_last_next  = 1'b0;
                        idx_next     = idx_reg + 1'b1;
                        state_next   = nte_pkg::ST_PURGE_RD;
                    end
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = wr_reg[IDX_W-1:0];
                    wr_next = wr_reg + 1'b1;
                    // First surviving match answers a query
                    if ((kind_reg == nte_pkg::KIND_QUERY) && addr_hit && !found_reg) begin
                        found_next = 1'b1;
                        rem_next   = rd_exp_reg - now_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = nte_pkg::ST_PURGE_RD;
                end
            end

            // Emit the closing transaction
            nte_pkg::ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_found_next = found_reg;
                    o_rem_next   = rem_reg;
                    o_full_next  = full_reg;
                    o_last_next  = 1'b1;
                    o_addr_next  = addr_reg;
                    if (kind_reg == nte_pkg::KIND_QUERY) begin
                        o_kind_next = nte_pkg::RPT_ANSWER;
                    end else begin
                        o_kind_next = nte_pkg::RPT_DONE;
                    end
                    if (kind_reg == nte_pkg::KIND_TICK) begin
                        o_addr_next = '0;
                    end
                    state_next = nte_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = nte_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the result channel
    assign m_valid       = m_valid_reg;
    assign m_report_kind = o_kind_reg;
    assign m_link_addr   = o_addr_reg;
    assign m_found       = o_found_reg;
    assign m_remaining   = o_rem_reg;
    assign m_table_full  = o_full_reg;
    assign m_last        = o_last_reg;

endmodule

@@ tb/sv/tb_neighbor_table_with_expiry_unit.sv @@
// Testbench for the neighbor table with expiry: directed and random traffic against a scoreboard.
`timescale 1ns / 100ps

module tb_neighbor_table_with_expiry_unit;

    localparam int unsigned DEPTH  = 16;
    localparam int unsigned TW     = 32;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int POOL_SIZE       = 20;
    localparam int HOLD_CYCLES     = 400;

    typedef struct {
        nte_pkg::rpt_kind_t report_kind;
        logic [15:0]        link_addr;
        logic               found;
        logic [TW-1:0]      remaining;
        logic               table_full;
        logic               last;
    } link_report_t;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    logic           cfg_wr_data;
    logic           s_valid;
    logic           s_ready;
    logic [1:0]     s_kind;
    logic [15:0]    s_addr;
    logic [TW-1:0]  s_lifetime;
    logic [TW-1:0]  s_now;
    logic           m_valid;
    logic           m_ready;
    logic [1:0]     m_report_kind;
    logic [15:0]    m_link_addr;
    logic           m_found;
    logic [TW-1:0]  m_remaining;
    logic           m_table_full;
    logic           m_last;

    // Shadow copy of the neighbor table and the report setting
    logic [15:0]    nbr_addr   [DEPTH];
    logic [TW-1:0]  nbr_expiry [DEPTH];
    logic           nbr_closed [DEPTH];
    int             nbr_count;
    logic           report_on;

    link_report_t   expected_reports[$];

    int             err_count;
    int             items_sent;
    int             results_seen;
    int             failures_seen;
    int             drops_seen;
    bit             gaps_on;
    int             hold_req;
    int             hold_taken;
    int             hold_left;
    logic [TW-1:0]  cur_time;
    logic [15:0]    addr_pool[POOL_SIZE];

    neighbor_table_with_expiry_unit #(
        .TABLE_DEPTH (DEPTH),
        .TIME_BITS   (TW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_addr        (s_addr),
        .s_lifetime    (s_lifetime),
        .s_now         (s_now),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_report_kind (m_report_kind),
        .m_link_addr   (m_link_addr),
        .m_found       (m_found),
        .m_remaining   (m_remaining),
        .m_table_full  (m_table_full),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Queue one expected result transaction
    function automatic void expect_report(nte_pkg::rpt_kind_t k, logic [15:0] a, logic f,
                                          logic [TW-1:0] rem, logic full, logic lst);
        link_report_t r;
        r.report_kind = k;
        r.link_addr   = a;
        r.found       = f;
        r.remaining   = rem;
        r.table_full  = full;
        r.last        = lst;
        expected_reports = {expected_reports, r};
    endfunction

    // Drop expired or closed entries, keep survivor order, report the removed ones
    function automatic void purge_expired(logic [TW-1:0] now_t);
        int w;
        w = 0;
        for (int r = 0; r < nbr_count; r++) begin
            if (nbr_expiry[r] < now_t || nbr_closed[r]) begin
                if (report_on)
                    expect_report(nte_pkg::RPT_FAILURE, nbr_addr[r], 1'b0, '0, 1'b0, 1'b0);
            end else begin
                nbr_addr[w]   = nbr_addr[r];
                nbr_expiry[w] = nbr_expiry[r];
                nbr_closed[w] = nbr_closed[r];
                w++;
            end
        end
        nbr_count = w;
    endfunction

    // Advance the shadow table by one accepted transaction and queue its results
    function automatic void table_step(nte_pkg::kind_t k, logic [15:0] a, logic [TW-1:0] life,
                                       logic [TW-1:0] now_t);
        logic [TW:0]   sum;
        logic [TW-1:0] new_exp;
        logic [TW-1:0] left;
        logic          full;
        logic          hit;
        logic          found;
        full  = 1'b0;
        hit   = 1'b0;
        found = 1'b0;
        left  = '0;
        case (k)
            nte_pkg::KIND_UPDATE: begin
                // saturate the new expiry at the largest time value
                sum     = {1'b0, life} + {1'b0, now_t};
                new_exp = sum[TW] ? '1 : sum[TW-1:0];
                for (int i = 0; i < nbr_count; i++) begin
                    if (!hit && nbr_addr[i] == a) begin
                        hit = 1'b1;
                        if (new_exp > nbr_expiry[i])
                            nbr_expiry[i] = new_exp;
                    end
                end
                // a miss appends (or is dropped when full) and then purges
                if (!hit) begin
                    if (nbr_count < DEPTH) begin
                        nbr_addr[nbr_count]   = a;
                        nbr_expiry[nbr_count] = new_exp;
                        nbr_closed[nbr_count] = 1'b0;
                        nbr_count++;
                    end else begin
                        full = 1'b1;
                    end
                    purge_expired(now_t);
                end
                expect_report(nte_pkg::RPT_DONE, a, 1'b0, '0, full, 1'b1);
            end
            nte_pkg::KIND_QUERY: begin
                purge_expired(now_t);
                for (int i = 0; i < nbr_count; i++) begin
                    if (!found && nbr_addr[i] == a) begin
                        found = 1'b1;
                        left  = nbr_expiry[i] - now_t;
                    end
                end
                expect_report(nte_pkg::RPT_ANSWER, a, found, left, 1'b0, 1'b1);
            end
            nte_pkg::KIND_TXERR: begin
                for (int i = 0; i < nbr_count; i++)
                    if (nbr_addr[i] == a)
                        nbr_closed[i] = 1'b1;
                purge_expired(now_t);
                expect_report(nte_pkg::RPT_DONE, a, 1'b0, '0, 1'b0, 1'b1);
            end
            default: begin
                purge_expired(now_t);
                expect_report(nte_pkg::RPT_DONE, 16'h0000, 1'b0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    // Offer one transaction from a falling edge; return at a falling edge with valid low
    task automatic send_item(nte_pkg::kind_t k, logic [15:0] a, logic [TW-1:0] life,
                             logic [TW-1:0] now_t);
        while (gaps_on && $urandom_range(0, 99) < 12) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_kind     = k;
        s_addr     = a;
        s_lifetime = life;
        s_now      = now_t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        table_step(k, a, life, now_t);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Hold until every expected result has come out, then let the design settle
    task automatic wait_idle();
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_report_cfg(logic on);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = on;
        @(posedge aclk);
        report_on = on;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly well-formed traffic on a small address pool with advancing time, some noise
    task automatic send_random_item();
        int             pick;
        nte_pkg::kind_t k;
        logic [15:0]    a;
        logic [TW-1:0]  life;
        logic [TW-1:0]  now_t;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            k     = nte_pkg::kind_t'($urandom_range(0, 3));
            a     = 16'($urandom_range(0, 65535));
            life  = $urandom;
            now_t = $urandom;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                k = nte_pkg::KIND_UPDATE;
            else if (pick < 75)
                k = nte_pkg::KIND_QUERY;
            else if (pick < 85)
                k = nte_pkg::KIND_TXERR;
            else
                k = nte_pkg::KIND_TICK;
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < 5)
                life = $urandom;
            else
                life = $urandom_range(0, 300);
            // occasional jump ages out most of the table at once
            if ($urandom_range(0, 99) < 3)
                cur_time += $urandom_range(200, 2000);
            else
                cur_time += $urandom_range(0, 25);
            now_t = cur_time;
        end
        send_item(k, a, life, now_t);
    endtask

    task automatic test_empty_table();
        send_item(nte_pkg::KIND_QUERY, 16'h0000, '0, '0);
        send_item(nte_pkg::KIND_TICK, 16'hFFFF, '1, '0);
    endtask

    task automatic test_update_query();
        // expiry equal to now stays current
        send_item(nte_pkg::KIND_UPDATE, 16'hFFFF, '0, '0);
        send_item(nte_pkg::KIND_QUERY, 16'hFFFF, '0, '0);
        // extend, then a shorter lifetime leaves the expiry alone
        send_item(nte_pkg::KIND_UPDATE, 16'hFFFF, 32'd100, 32'd5);
        send_item(nte_pkg::KIND_UPDATE, 16'hFFFF, 32'd10, 32'd5);
        send_item(nte_pkg::KIND_QUERY, 16'hFFFF, '0, 32'd50);
    endtask

    task automatic test_time_saturation();
        send_item(nte_pkg::KIND_UPDATE, 16'h8001, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_item(nte_pkg::KIND_QUERY, 16'h8001, 32'hFFFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_close_and_reports();
        write_report_cfg(1'b1);
        send_item(nte_pkg::KIND_UPDATE, 16'h0001, 32'd50, 32'h8000_0010);
        send_item(nte_pkg::KIND_TXERR, 16'h0001, '0, 32'h8000_0020);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH - 1; i++)
            send_item(nte_pkg::KIND_UPDATE, 16'h0100 + 16'(i), TW'(10 * i), 32'h8000_0200);
        // insert into a full table is dropped, the purge still removes the oldest
        send_item(nte_pkg::KIND_UPDATE, 16'h0200, 32'd10, 32'h8000_0223);
    endtask

    task automatic test_random_traffic(int n);
        repeat (n) send_random_item();
    endtask

    // Stall the output for a long stretch while traffic keeps coming, then drain
    task automatic test_output_backpressure(int n);
        gaps_on = 1'b0;
        hold_req++;
        repeat (n) send_random_item();
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_idle_free_stretch(int n);
        gaps_on = 1'b0;
        repeat (n) send_random_item();
        gaps_on = 1'b1;
    endtask

    task automatic test_time_wrap(int n);
        cur_time = 32'hFFFF_FF00;
        repeat (n) send_random_item();
    endtask

    // Result side ready: long hold when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_req != hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_req;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = !(gaps_on && $urandom_range(0, 99) < 12);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        link_report_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_report_kind == nte_pkg::RPT_FAILURE)
                failures_seen++;
            if (m_table_full)
                drops_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected result: report_kind %0d link_addr %h",
                       m_report_kind, m_link_addr);
                err_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("report_kind", TW'(want.report_kind), TW'(m_report_kind));
                check_field("link_addr", TW'(want.link_addr), TW'(m_link_addr));
                check_field("found", TW'(want.found), TW'(m_found));
                check_field("remaining", want.remaining, m_remaining);
                check_field("table_full", TW'(want.table_full), TW'(m_table_full));
                check_field("last", TW'(want.last), TW'(m_last));
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_valid       = 1'b0;
        s_kind        = nte_pkg::KIND_UPDATE;
        s_addr        = '0;
        s_lifetime    = '0;
        s_now         = '0;
        nbr_count     = 0;
        report_on     = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        results_seen  = 0;
        failures_seen = 0;
        drops_seen    = 0;
        gaps_on       = 1'b1;
        hold_req      = 0;
        cur_time      = '0;
        addr_pool[0]  = 16'h0000;
        addr_pool[1]  = 16'hFFFF;
        addr_pool[2]  = 16'h5555;
        addr_pool[3]  = 16'hAAAA;
        for (int i = 4; i < POOL_SIZE; i++)
            addr_pool[i] = 16'($urandom_range(0, 65535));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_report_cfg(1'b0);
        test_empty_table();
        test_update_query();
        test_time_saturation();
        test_close_and_reports();
        test_full_table();

        cur_time = 32'h8000_0300;
        test_random_traffic(70);
        test_output_backpressure(40);
        write_report_cfg(1'b0);
        test_idle_free_stretch(50);
        test_random_traffic(60);
        write_report_cfg(1'b1);
        test_time_wrap(30);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d transactions in, %0d results checked, %0d link failures, %0d drops",
                 items_sent, results_seen, failures_seen, drops_seen);
        $display("Covered all kinds, both report settings, full table, saturation, time wrap, stalls");
        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/nte_pkg.sv
hw/rtl/neighbor_table_with_expiry_unit.sv
tb/sv/tb_neighbor_table_with_expiry_unit.sv
